>>> rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low.
`define TKH_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low.
`define TKH_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/tkh_pkg.sv
package tkh_pkg;

	localparam int TKH_DEPTH  = 64;
	localparam int TKH_AW     = $clog2(TKH_DEPTH);
	localparam int TKH_CW     = $clog2(TKH_DEPTH + 1);
	localparam int TKH_XW     = TKH_AW + 2;
	localparam int TKH_SW     = 32;
	localparam int TKH_SLOT_W = 2 * TKH_SW;
	localparam int TKH_CAP_W  = 7;
	localparam int TKH_OCC_W  = 7;
	localparam int TKH_LIM_W  = 8;
	localparam int TKH_RES_W  = 2 * TKH_SW + TKH_OCC_W + 2;
	localparam int TKH_OUT_W  = ((TKH_RES_W + 7) / 8) * 8;

	localparam logic [TKH_CAP_W-1:0] TKH_CAP_RST = 7'd64;

	localparam logic KIND_ADD   = 1'b0;
	localparam logic KIND_DRAIN = 1'b1;

	// score in the low half
	typedef struct packed {
		logic [TKH_SW-1:0]        tag;
		logic signed [TKH_SW-1:0] score;
	} tkh_slot_t;

	typedef struct packed {
		logic                     last;
		logic                     emp;
		logic                     acc;
		logic [TKH_OCC_W-1:0]     occ;
		logic [TKH_SW-1:0]        tag;
		logic signed [TKH_SW-1:0] score;
	} tkh_res_t;

	typedef struct packed {
		logic                  we;
		logic [TKH_AW-1:0]     waddr;
		logic [TKH_SLOT_W-1:0] wdata;
		logic                  re;
		logic [TKH_AW-1:0]     raddr;
	} tkh_mem_req_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ROOT,
		ST_UP_RD,
		ST_UP_CMP,
		ST_DN_RD,
		ST_DN_LEFT,
		ST_DN_SEL,
		ST_DN_CMP,
		ST_DR_RD,
		ST_DR_TOP,
		ST_DR_LAST,
		ST_EMIT
	} tkh_state_t;

endpackage

>>> rtl/tkh_ram.sv
module tkh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

>>> rtl/tkh_cmp.sv
module tkh_cmp
	import tkh_pkg::*;
(
	input  logic signed [TKH_SW-1:0] a,
	input  logic signed [TKH_SW-1:0] b,
	output logic                     lt
);

	// signed strict less-than
	assign lt = (a < b);

endmodule

>>> rtl/tkh_ctrl.sv
module tkh_ctrl
	import tkh_pkg::*;
(
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic [TKH_CAP_W-1:0]     cap,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic                     in_kind,
	input  tkh_slot_t                in_slot,
	output logic                     res_valid,
	input  logic                     res_ready,
	output tkh_res_t                 res,
	output tkh_mem_req_t             mem_req,
	input  tkh_slot_t                mem_rdata,
	output logic signed [TKH_SW-1:0] cmp_a,
	output logic signed [TKH_SW-1:0] cmp_b,
	input  logic                     cmp_lt
);

	localparam logic [TKH_LIM_W-1:0] DEPTH_LIM = TKH_LIM_W'(TKH_DEPTH);

	tkh_state_t state_q, state_d;

	logic [TKH_CW-1:0]  held_q, held_d;
	logic               kind_q, kind_d;
	logic [TKH_AW-1:0]  idx_q, idx_d;
	logic [TKH_AW-1:0]  cidx_q, cidx_d;
	tkh_slot_t          item_q, item_d;
	tkh_slot_t          child_q, child_d;
	tkh_slot_t          top_q, top_d;
	logic               acc_q, acc_d;
	logic               emp_q, emp_d;

	logic [TKH_LIM_W-1:0] cap_lim;
	logic [TKH_LIM_W-1:0] held_lim;
	logic [TKH_AW-1:0]    par_idx;
	logic [TKH_XW-1:0]    lchild;
	logic [TKH_XW-1:0]    rchild;
	logic [TKH_XW-1:0]    held_x;
	logic [TKH_CW-1:0]    held_m1;

	assign cap_lim  = ({1'b0, cap} > DEPTH_LIM) ? DEPTH_LIM : {1'b0, cap};
	assign held_lim = TKH_LIM_W'(held_q);
	assign par_idx  = TKH_AW'(idx_q - 1'b1) >> 1;
	assign lchild   = TKH_XW'({idx_q, 1'b1});
	assign rchild   = lchild + 1'b1;
	assign held_x   = TKH_XW'(held_q);
	assign held_m1  = held_q - 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			held_q  <= '0;
			kind_q  <= KIND_ADD;
			acc_q   <= 1'b0;
			emp_q   <= 1'b0;
		end else begin
			state_q <= state_d;
			held_q  <= held_d;
			kind_q  <= kind_d;
			acc_q   <= acc_d;
			emp_q   <= emp_d;
		end
	end

	always_ff @(posedge clk) begin
		idx_q   <= idx_d;
		cidx_q  <= cidx_d;
		item_q  <= item_d;
		child_q <= child_d;
		top_q   <= top_d;
	end

	always_comb begin
		state_d = state_q;
		held_d  = held_q;
		kind_d  = kind_q;
		idx_d   = idx_q;
		cidx_d  = cidx_q;
		item_d  = item_q;
		child_d = child_q;
		top_d   = top_q;
		acc_d   = acc_q;
		emp_d   = emp_q;

		in_ready      = 1'b0;
		res_valid     = 1'b0;
		mem_req.we    = 1'b0;
		mem_req.waddr = idx_q;
		mem_req.wdata = item_q;
		mem_req.re    = 1'b0;
		mem_req.raddr = '0;
		cmp_a         = item_q.score;
		cmp_b         = item_q.score;

		unique case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					item_d = in_slot;
					kind_d = in_kind;
					top_d  = '0;
					acc_d  = 1'b0;
					emp_d  = 1'b0;
					if (in_kind == KIND_ADD) begin
						if (held_lim < cap_lim) begin
							idx_d   = held_q[TKH_AW-1:0];
							held_d  = held_q + 1'b1;
							acc_d   = 1'b1;
							state_d = ST_UP_RD;
						end else if (held_q != '0) begin
							mem_req.re = 1'b1;
							state_d    = ST_ROOT;
						end else begin
							state_d = ST_EMIT;
						end
					end else if (held_q == '0) begin
						emp_d   = 1'b1;
						state_d = ST_EMIT;
					end else begin
						mem_req.re = 1'b1;
						state_d    = ST_DR_TOP;
					end
				end
			end
			ST_ROOT: begin
				// replace root only if it is strictly below the new score
				cmp_a = mem_rdata.score;
				cmp_b = item_q.score;
				if (cmp_lt) begin
					acc_d   = 1'b1;
					idx_d   = '0;
					state_d = ST_DN_RD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_UP_RD: begin
				if (idx_q == '0) begin
					mem_req.we = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = par_idx;
					state_d       = ST_UP_CMP;
				end
			end
			ST_UP_CMP: begin
				cmp_a = item_q.score;
				cmp_b = mem_rdata.score;
				mem_req.we = 1'b1;
				if (cmp_lt) begin
					mem_req.wdata = mem_rdata;
					idx_d         = par_idx;
					state_d       = ST_UP_RD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DN_RD: begin
				if (lchild >= held_x) begin
					mem_req.we = 1'b1;
					state_d    = ST_EMIT;
				end else begin
					mem_req.re    = 1'b1;
					mem_req.raddr = lchild[TKH_AW-1:0];
					state_d       = ST_DN_LEFT;
				end
			end
			ST_DN_LEFT: begin
				child_d = mem_rdata;
				cidx_d  = lchild[TKH_AW-1:0];
				if (rchild < held_x) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = rchild[TKH_AW-1:0];
					state_d       = ST_DN_SEL;
				end else begin
					state_d = ST_DN_CMP;
				end
			end
			ST_DN_SEL: begin
				// right child wins only when strictly smaller
				cmp_a = mem_rdata.score;
				cmp_b = child_q.score;
				if (cmp_lt) begin
					child_d = mem_rdata;
					cidx_d  = cidx_q + 1'b1;
				end
				state_d = ST_DN_CMP;
			end
			ST_DN_CMP: begin
				cmp_a = child_q.score;
				cmp_b = item_q.score;
				mem_req.we = 1'b1;
				if (cmp_lt) begin
					mem_req.wdata = child_q;
					idx_d         = cidx_q;
					state_d       = ST_DN_RD;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DR_RD: begin
				mem_req.re = 1'b1;
				state_d    = ST_DR_TOP;
			end
			ST_DR_TOP: begin
				top_d  = mem_rdata;
				held_d = held_m1;
				if (held_m1 != '0) begin
					mem_req.re    = 1'b1;
					mem_req.raddr = held_m1[TKH_AW-1:0];
					state_d       = ST_DR_LAST;
				end else begin
					state_d = ST_EMIT;
				end
			end
			ST_DR_LAST: begin
				item_d  = mem_rdata;
				idx_d   = '0;
				state_d = ST_DN_RD;
			end
			ST_EMIT: begin
				res_valid = 1'b1;
				if (res_ready) begin
					if (kind_q == KIND_DRAIN && held_q != '0) begin
						state_d = ST_DR_RD;
					end else begin
						state_d = ST_IDLE;
					end
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	assign res.score = top_q.score;
	assign res.tag   = top_q.tag;
	assign res.occ   = TKH_OCC_W'(held_q);
	assign res.acc   = acc_q;
	assign res.emp   = emp_q;
	assign res.last  = (kind_q == KIND_ADD) || (held_q == '0);

endmodule

>>> rtl/top_k_min_heap_top.sv
// Top-K min-heap. Keeps the highest-scoring entries seen so far, up to the
// capacity register (0..127, reset 64, saturates at 64), in a binary min-heap
// on signed 32-bit score held in a 64-entry single-port-read RAM. An add
// word (tuser 0) either takes a free slot and sifts up, or, when the heap is
// full, replaces the root if the root scores strictly lower and sifts down
// toward the smaller child (left on a tie); it returns one word with
// accepted and occupancy. A drain word (tuser 1) returns every entry in
// ascending score, tlast on the final one, and leaves the heap empty; a
// drain of an empty heap returns one word with empty_res and tlast set.
// Heap work does at most one RAM read and one compare per cycle, through
// a single shared signed comparator. An add into free room reads and
// compares each parent on the way up; a replace-root add reads the root,
// then per level it sinks reads the children, picks one and compares it.
// A drain reads the root and the last entry, then sinks the last entry
// from the root. s_tready is high only while the sequencer is idle; one
// output register lets the next item in while the last result word waits
// on m_tready. Capacity must be written through cfg_valid/cfg_data only
// while the block is idle; the block itself does not enforce this.
module top_k_min_heap_top
	import tkh_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// capacity register write
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [TKH_CAP_W-1:0] cfg_data,
	// input words
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [2*TKH_SW-1:0]  s_tdata,  // [31:0] new_score, [63:32] new_tag
	input  logic                 s_tuser,  // kind: 0 add, 1 drain
	// result words
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [TKH_OUT_W-1:0] m_tdata,  // [31:0] entry_score, [63:32] entry_tag,
	                                       // [70:64] occupancy, [71] accepted,
	                                       // [72] empty_res, rest zero
	output logic                 m_tlast   // last
);

	logic [TKH_CAP_W-1:0] cap_q;

	tkh_slot_t    in_slot;
	tkh_slot_t    rd_slot;
	tkh_res_t     res;
	tkh_res_t     out_q;
	tkh_mem_req_t mem_req;

	logic                     res_valid;
	logic                     res_ready;
	logic                     out_valid_q;
	logic [TKH_SLOT_W-1:0]    ram_rdata;
	logic signed [TKH_SW-1:0] cmp_a;
	logic signed [TKH_SW-1:0] cmp_b;
	logic                     cmp_lt;

	// capacity register; always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q <= TKH_CAP_RST;
		end else if (cfg_valid) begin
			cap_q <= cfg_data;
		end
	end

	assign in_slot = tkh_slot_t'(s_tdata);
	assign rd_slot = tkh_slot_t'(ram_rdata);

	tkh_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.cap       (cap_q),
		.in_valid  (s_tvalid),
		.in_ready  (s_tready),
		.in_kind   (s_tuser),
		.in_slot   (in_slot),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.mem_req   (mem_req),
		.mem_rdata (rd_slot),
		.cmp_a     (cmp_a),
		.cmp_b     (cmp_b),
		.cmp_lt    (cmp_lt)
	);

	// the one comparator all sift steps share
	tkh_cmp u_cmp (
		.a  (cmp_a),
		.b  (cmp_b),
		.lt (cmp_lt)
	);

	tkh_ram #(
		.WIDTH (TKH_SLOT_W),
		.DEPTH (TKH_DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.waddr (mem_req.waddr),
		.wdata (mem_req.wdata),
		.re    (mem_req.re),
		.raddr (mem_req.raddr),
		.rdata (ram_rdata)
	);

	// output register: loads when empty or being drained this cycle
	assign res_ready = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (res_ready) begin
			out_valid_q <= res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (res_ready && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {{(TKH_OUT_W - TKH_RES_W){1'b0}}, out_q.emp, out_q.acc, out_q.occ,
		out_q.tag, out_q.score};

endmodule

>>> rtl/tkh_chk.sv
`include "assert_macros.svh"

module tkh_chk
	import tkh_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 s_tvalid,
	input logic                 s_tready,
	input logic                 m_tvalid,
	input logic                 m_tready,
	input logic [TKH_OUT_W-1:0] m_tdata,
	input logic                 m_tlast
);

	localparam int OCC_LO = 2 * TKH_SW;
	localparam int ACC_B  = OCC_LO + TKH_OCC_W;
	localparam int EMP_B  = ACC_B + 1;

	logic [TKH_OCC_W-1:0] occ;

	assign occ = m_tdata[ACC_B-1:OCC_LO];

	// held result word must not change while stalled
	`TKH_ASSERT_NEXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "result word changed while stalled")

	// the sequencer is never ready in the cycle after it takes an item
	`TKH_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready, "input taken on back-to-back cycles")

	// only drain words can be non-final, and they carry no add or empty flag
	`TKH_ASSERT_NOW(a_mid_drain, m_tvalid && !m_tlast, !m_tdata[ACC_B] && !m_tdata[EMP_B], "non-final word with flags")

	// empty drain is a single final word with nothing held
	`TKH_ASSERT_NOW(a_empty_word, m_tvalid && m_tdata[EMP_B], m_tlast && (occ == '0) && !m_tdata[ACC_B], "bad empty-drain word")

	// occupancy never exceeds the heap depth
	`TKH_ASSERT_NOW(a_occ_bound, m_tvalid, occ <= TKH_OCC_W'(TKH_DEPTH), "occupancy above depth")

endmodule

bind top_k_min_heap_top tkh_chk u_chk (.*);

>>> sim/top_k_min_heap_top_test.sv
`timescale 1ns / 1ps

module top_k_min_heap_top_test;
	import tkh_pkg::*;

	localparam int LIMIT_CYCLES = 400000;
	localparam int SETTLE_CYCLES = 40;   // longest add walk plus margin
	localparam int RAND_ITEMS = 480;
	localparam int HOLD_AT = 60;         // random word count that triggers the long sink stall
	localparam int HOLD_CYCLES = 400;
	localparam int IDLE_PCT = 23;

	typedef enum logic [1:0] {ROW_ADD, ROW_DRAIN, ROW_CAP} row_op_t;

	typedef struct {
		row_op_t                  op;
		logic signed [TKH_SW-1:0] score;  // capacity value on ROW_CAP
		logic [TKH_SW-1:0]        tag;
		bit                       typed;  // want below is used instead of the heap model
		tkh_res_t                 want;
	} row_t;

	logic                 clk = 1'b0;
	logic                 arst_n;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [TKH_CAP_W-1:0] cfg_data;
	logic                 s_tvalid;
	logic                 s_tready;
	logic [2*TKH_SW-1:0]  s_tdata;
	logic                 s_tuser;
	logic                 m_tvalid;
	logic                 m_tready;
	logic [TKH_OUT_W-1:0] m_tdata;
	logic                 m_tlast;

	// heap model state
	logic signed [TKH_SW-1:0] kept_score [TKH_DEPTH];
	logic [TKH_SW-1:0]        kept_tag [TKH_DEPTH];
	int                       kept_count;
	logic [TKH_CAP_W-1:0]     cap_value;

	tkh_res_t pending_words[$];  // result words still owed by the block
	tkh_res_t heap_out[$];       // words produced by the last model step
	row_t     dir_rows[$];
	tkh_res_t got_want;
	int       errors;
	int       cycles;
	bit       quiet;     // no idling on either side
	bit       hold_req;  // ask the sink for one long stall

	top_k_min_heap_top i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_data (cfg_data),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast)
	);

	always #4 clk = ~clk;

	// Place an entry at the root of an n-entry heap and walk it down, smaller child,
	// left on a tie.
	task automatic sift_from_root(input logic signed [TKH_SW-1:0] sc,
	                              input logic [TKH_SW-1:0] tg, input int n);
		int p;
		int c;
		p = 0;
		c = 1;
		while (c < n) begin
			if (c + 1 < n && kept_score[c+1] < kept_score[c])
				c++;
			if (!(kept_score[c] < sc))
				break;
			kept_score[p] = kept_score[c];
			kept_tag[p] = kept_tag[c];
			p = c;
			c = 2 * p + 1;
		end
		kept_score[p] = sc;
		kept_tag[p] = tg;
	endtask

	// Advance the heap model by one word; fills heap_out with the words it owes.
	task automatic heap_update(input logic kind, input logic signed [TKH_SW-1:0] sc,
	                           input logic [TKH_SW-1:0] tg);
		tkh_res_t r;
		int lim;
		int i;
		int p;
		heap_out.delete();
		r = '0;
		if (kind == KIND_ADD) begin
			lim = int'(cap_value);
			if (lim > TKH_DEPTH)
				lim = TKH_DEPTH;
			if (kept_count < lim) begin
				// free room: sift up, strict less-than
				i = kept_count;
				kept_count++;
				while (i > 0) begin
					p = (i - 1) / 2;
					if (!(sc < kept_score[p]))
						break;
					kept_score[i] = kept_score[p];
					kept_tag[i] = kept_tag[p];
					i = p;
				end
				kept_score[i] = sc;
				kept_tag[i] = tg;
				r.acc = 1'b1;
			end else if (kept_count > 0 && kept_score[0] < sc) begin
				// full (or over capacity): replace root only if strictly lower
				sift_from_root(sc, tg, kept_count);
				r.acc = 1'b1;
			end
			r.occ = TKH_OCC_W'(kept_count);
			r.last = 1'b1;
			heap_out.push_back(r);
		end else if (kept_count == 0) begin
			r.emp = 1'b1;
			r.last = 1'b1;
			heap_out.push_back(r);
		end else begin
			while (kept_count > 0) begin
				r = '0;
				r.score = kept_score[0];
				r.tag = kept_tag[0];
				kept_count--;
				if (kept_count > 0)
					sift_from_root(kept_score[kept_count], kept_tag[kept_count], kept_count);
				r.occ = TKH_OCC_W'(kept_count);
				r.last = (kept_count == 0);
				heap_out.push_back(r);
			end
		end
	endtask

	task automatic put_row(input row_op_t op, input logic signed [TKH_SW-1:0] val,
	                       input logic [TKH_SW-1:0] tg, input bit typed = 1'b0,
	                       input int occ = 0, input bit acc = 1'b0, input bit emp = 1'b0);
		row_t r;
		r.op = op;
		r.score = val;
		r.tag = tg;
		r.typed = typed;
		r.want = '0;
		r.want.occ = TKH_OCC_W'(occ);
		r.want.acc = acc;
		r.want.emp = emp;
		r.want.last = 1'b1;
		dir_rows.push_back(r);
	endtask

	// Offer one input word, with a random gap first; called at a rising edge,
	// returns at the edge that took the word, tvalid still high.
	task automatic send_word(input logic kind, input logic signed [TKH_SW-1:0] sc,
	                         input logic [TKH_SW-1:0] tg, input bit typed, input tkh_res_t want);
		if (!quiet && $urandom_range(0, 99) < IDLE_PCT) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while (!quiet && $urandom_range(0, 99) < IDLE_PCT);
		end
		s_tvalid <= 1'b1;
		s_tuser <= kind;
		s_tdata <= {tg, sc};
		forever begin
			@(negedge clk);
			if (s_tready)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		heap_update(kind, sc, tg);
		if (typed)
			pending_words.push_back(want);
		else
			foreach (heap_out[j])
				pending_words.push_back(heap_out[j]);
	endtask

	// Capacity goes in only with the block idle: every owed word back, then a settle time.
	task automatic write_capacity(input logic [TKH_CAP_W-1:0] v);
		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_valid <= 1'b1;
		cfg_data <= v;
		forever begin
			@(negedge clk);
			if (cfg_ready)
				break;
			@(posedge clk);
		end
		@(posedge clk);
		cfg_valid <= 1'b0;
		cap_value = v;
	endtask

	function automatic logic signed [TKH_SW-1:0] pick_score();
		case ($urandom_range(0, 9))
			0: return 32'sh8000_0000;
			1: return 32'sh7fff_ffff;
			2, 3, 4: return $urandom_range(0, 15) - 8;  // narrow range: lots of ties
			default: return $urandom();
		endcase
	endfunction

	task automatic check_field(input string name, input logic [TKH_SW-1:0] want,
	                           input logic [TKH_SW-1:0] got);
		if (want !== got) begin
			$error("%s: expected %0h, got %0h", name, want, got);
			errors++;
		end
	endtask

	// Result words are checked at the falling edge before the rising edge that takes them.
	always @(negedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (pending_words.size() == 0) begin
				$error("result word with nothing expected: tdata %0h", m_tdata);
				errors++;
			end else begin
				got_want = pending_words.pop_front();
				check_field("entry_score", got_want.score, m_tdata[31:0]);
				check_field("entry_tag", got_want.tag, m_tdata[63:32]);
				check_field("occupancy", TKH_SW'(got_want.occ), TKH_SW'(m_tdata[70:64]));
				check_field("accepted", TKH_SW'(got_want.acc), TKH_SW'(m_tdata[71]));
				check_field("empty_res", TKH_SW'(got_want.emp), TKH_SW'(m_tdata[72]));
				check_field("tdata_pad", '0, TKH_SW'(m_tdata[TKH_OUT_W-1:TKH_RES_W]));
				check_field("last", TKH_SW'(got_want.last), TKH_SW'(m_tlast));
			end
		end
	end

	// Sink: random backpressure, one long stall on request.
	initial begin
		m_tready = 1'b0;
		forever begin
			@(posedge clk);
			if (hold_req) begin
				m_tready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				hold_req = 1'b0;
			end
			m_tready <= quiet || ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles == LIMIT_CYCLES) begin
			$display("top_k_min_heap_top_test: FAIL");
			$finish;
		end
	end

	initial begin
		row_t r;
		int sent;
		int n_add;
		logic [TKH_CAP_W-1:0] cap;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = KIND_ADD;
		errors = 0;
		cycles = 0;
		quiet = 1'b0;
		hold_req = 1'b0;
		kept_count = 0;
		cap_value = TKH_CAP_RST;
		sent = 0;

		// Directed words. Typed rows: drain of an empty heap, extremes, capacity corners.
		put_row(ROW_DRAIN, 0, 0, 1, 0, 0, 1);
		put_row(ROW_ADD, 32'sh8000_0000, 32'h0000_0000, 1, 1, 1);
		put_row(ROW_ADD, 32'sh7fff_ffff, 32'hffff_ffff, 1, 2, 1);
		put_row(ROW_ADD, 0, 32'h5555_5555, 1, 3, 1);
		put_row(ROW_ADD, -1, 32'haaaa_aaaa, 1, 4, 1);
		put_row(ROW_ADD, -1, 32'h0000_1234, 1, 5, 1);   // tie with a held score
		put_row(ROW_DRAIN, 0, 0);
		put_row(ROW_CAP, 0, 0);                         // capacity zero
		put_row(ROW_ADD, 5, 32'h1, 1, 0, 0);            // rejected
		put_row(ROW_DRAIN, 0, 0, 1, 0, 0, 1);
		put_row(ROW_CAP, 1, 0);
		put_row(ROW_ADD, 10, 32'h1, 1, 1, 1);
		put_row(ROW_ADD, 10, 32'h2, 1, 1, 0);           // equal to root: kept out
		put_row(ROW_ADD, 9, 32'h3, 1, 1, 0);
		put_row(ROW_ADD, 11, 32'h4, 1, 1, 1);           // replaces root
		put_row(ROW_CAP, 127, 0);                       // above depth, saturates
		put_row(ROW_ADD, -5, 32'h5);
		put_row(ROW_ADD, 20, 32'h6);
		put_row(ROW_ADD, 7, 32'h7);
		put_row(ROW_CAP, 2, 0);                         // below occupancy: heap is full
		put_row(ROW_ADD, 32'sh8000_0000, 32'h8, 1, 4, 0);
		put_row(ROW_ADD, 100, 32'h9, 1, 4, 1);
		put_row(ROW_ADD, -5, 32'ha);
		put_row(ROW_DRAIN, 0, 0);
		put_row(ROW_CAP, 64, 0);

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i]) begin
			r = dir_rows[i];
			if (r.op == ROW_CAP)
				write_capacity(r.score[TKH_CAP_W-1:0]);
			else
				send_word(r.op == ROW_DRAIN ? KIND_DRAIN : KIND_ADD, r.score, r.tag,
				          r.typed, r.want);
		end

		// Random phases: set a capacity with the block idle, a run of adds with the odd
		// stray drain, then usually a drain. A phase left undrained carries its heap
		// into the next capacity, often a lower one.
		while (sent < RAND_ITEMS) begin
			case ($urandom_range(0, 11))
				0: cap = 0;
				1: cap = 1;
				2, 3: cap = 64;
				4: cap = 127;
				5: cap = TKH_CAP_W'($urandom_range(65, 126));
				default: cap = TKH_CAP_W'($urandom_range(2, 40));
			endcase
			write_capacity(cap);
			if (cap >= 64 && $urandom_range(0, 1) == 1)
				n_add = $urandom_range(64, 90);
			else
				n_add = $urandom_range(1, 24);
			for (int k = 0; k < n_add; k++) begin
				quiet = (sent >= 200 && sent < 300);
				if (sent == HOLD_AT)
					hold_req = 1'b1;  // sink stalls while adds keep coming
				if ($urandom_range(0, 29) == 0)
					send_word(KIND_DRAIN, $urandom(), $urandom(), 1'b0, '0);
				else
					send_word(KIND_ADD, pick_score(), $urandom(), 1'b0, '0);
				sent++;
			end
			if ($urandom_range(0, 3) != 0) begin
				send_word(KIND_DRAIN, $urandom(), $urandom(), 1'b0, '0);
				sent++;
			end
		end
		quiet = 1'b0;

		s_tvalid <= 1'b0;
		while (pending_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (errors == 0)
			$display("top_k_min_heap_top_test: PASS");
		else
			$display("top_k_min_heap_top_test: FAIL");
		$finish;
	end

endmodule
